// File: rtl/avgp_pkg.sv
// Shared constants for the average pooling block: sizes, widths, register indexes.
// No dependencies.
package avgp_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_WINDOW = 8;

  localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int ROW_AW   = $clog2(MAX_WINDOW);
  localparam int COL_AW   = $clog2(MAX_WIDTH);
  localparam int LS_AW    = ROW_AW + COL_AW;

  // config register widths
  localparam int HW  = 16;               // heights
  localparam int WW  = COL_AW + 1;       // widths
  localparam int KW  = $clog2(MAX_WINDOW) + 1; // window and step fields (4 bit)
  localparam int CFG_DW = 16;
  localparam int CFG_AW = 3;

  // divider: window area up to MAX_WINDOW^2, sum magnitude up to area * 2^(PIXEL_BITS-1)
  localparam int DEN_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int NUM_W = PIXEL_BITS - 1 + 2 * ROW_AW + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int ACC_W = NUM_W + 1;

  typedef logic [CFG_AW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IN_HEIGHT  = 3'd0;
  localparam cfg_idx_t REG_IN_WIDTH   = 3'd1;
  localparam cfg_idx_t REG_OUT_HEIGHT = 3'd2;
  localparam cfg_idx_t REG_OUT_WIDTH  = 3'd3;
  localparam cfg_idx_t REG_WIN_HEIGHT = 3'd4;
  localparam cfg_idx_t REG_WIN_WIDTH  = 3'd5;
  localparam cfg_idx_t REG_STEP_ROWS  = 3'd6;
  localparam cfg_idx_t REG_STEP_COLS  = 3'd7;

endpackage

// File: rtl/avg_pool_window_stream.sv
// Streaming 2-D average pooling over signed Q8.8 pixels with a line store.
// Depends on avgp_pkg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------
//   input    | in_valid / in_stall     | pixel
//   output   | out_valid / out_stall   | average, plane_end
//   config   | cfg_we                  | cfg_index, cfg_data
//
// A pixel above or left of the first window corner starts no division. Any other pixel
// runs the row division and ends there if it is off the row stride or past the output
// height; else it runs the column division and ends there if it fails on the column.
// A pixel that closes a window then has the window summed and the mean divided:
// one shared bit-serial divider gives row position, column position and the mean,
// and the window is summed one line-store read per cycle.
// Reset (rst, synchronous) clears control and loads register defaults; the line
// store is not cleared. A stalled output word waits in its register while the
// next pixel is taken; a further word holds the input until that register frees.
module avg_pool_window_stream (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [avgp_pkg::PIXEL_BITS-1:0] pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [avgp_pkg::PIXEL_BITS-1:0] average,
  output logic                                  plane_end,
  input  logic                                  cfg_we,
  input  logic [avgp_pkg::CFG_AW-1:0]           cfg_index,
  input  logic [avgp_pkg::CFG_DW-1:0]           cfg_data
);
  import avgp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DROW = 3'd1;
  localparam logic [2:0] S_DCOL = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration registers
  logic [HW-1:0] in_height, out_height;
  logic [WW-1:0] in_width, out_width;
  logic [KW-1:0] win_height, win_width, step_rows, step_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height  <= HW'(32);
      in_width   <= WW'(32);
      out_height <= HW'(16);
      out_width  <= WW'(16);
      win_height <= KW'(2);
      win_width  <= KW'(2);
      step_rows  <= KW'(2);
      step_cols  <= KW'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_HEIGHT:  in_height  <= cfg_data[HW-1:0];
        REG_IN_WIDTH:   in_width   <= cfg_data[WW-1:0];
        REG_OUT_HEIGHT: out_height <= cfg_data[HW-1:0];
        REG_OUT_WIDTH:  out_width  <= cfg_data[WW-1:0];
        REG_WIN_HEIGHT: win_height <= cfg_data[KW-1:0];
        REG_WIN_WIDTH:  win_width  <= cfg_data[KW-1:0];
        REG_STEP_ROWS:  step_rows  <= cfg_data[KW-1:0];
        REG_STEP_COLS:  step_cols  <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes after clamping
  logic [HW-1:0] ih;
  logic [WW-1:0] iw;
  logic [KW-1:0] wh, ww, sh, sw;

  always_comb begin
    ih = (in_height == '0) ? HW'(1) : in_height;
    if (in_width == '0) iw = WW'(1);
    else if (in_width > WW'(MAX_WIDTH)) iw = WW'(MAX_WIDTH);
    else iw = in_width;
    if (win_height == '0) wh = KW'(1);
    else if (win_height > KW'(MAX_WINDOW)) wh = KW'(MAX_WINDOW);
    else wh = win_height;
    if (win_width == '0) ww = KW'(1);
    else if (win_width > KW'(MAX_WINDOW)) ww = KW'(MAX_WINDOW);
    else ww = win_width;
    sh = (step_rows == '0) ? KW'(1) : step_rows;
    sw = (step_cols == '0) ? KW'(1) : step_cols;
  end

  logic [2:0]  state;
  logic        accept;
  logic        out_take;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // raster position of the incoming pixel and of the one after it
  logic [HW-1:0]   row_pos, cur_r, row_next;
  logic [COL_AW-1:0] col_pos, cur_c, col_next;
  logic [HW:0]     r_pre, r_post;
  logic [WW-1:0]   c_inc;
  logic            gate;

  always_comb begin
    r_pre = {1'b0, row_pos};
    cur_c = col_pos;
    if ({1'b0, col_pos} >= iw) begin
      cur_c = '0;
      r_pre = r_pre + (HW+1)'(1);
    end
    cur_r = (r_pre >= {1'b0, ih}) ? '0 : r_pre[HW-1:0];
    c_inc = {1'b0, cur_c} + WW'(1);
    r_post = {1'b0, cur_r};
    col_next = c_inc[COL_AW-1:0];
    row_next = cur_r;
    if (c_inc >= iw) begin
      col_next = '0;
      r_post = r_post + (HW+1)'(1);
      row_next = (r_post >= {1'b0, ih}) ? '0 : r_post[HW-1:0];
    end
    gate = ({1'b0, cur_r} + (HW+1)'(1) >= (HW+1)'(wh)) && (c_inc >= WW'(ww));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      row_pos <= row_next;
      col_pos <= col_next;
    end
  end

  // line store: written on accept, read while summing a window
  logic signed [PIXEL_BITS-1:0] line_store [LS_DEPTH];
  logic signed [PIXEL_BITS-1:0] mem_q;
  logic [LS_AW-1:0] wr_addr, rd_addr;
  logic             mem_we;

  assign mem_we  = accept;
  assign wr_addr = {cur_r[ROW_AW-1:0], cur_c};

  always_ff @(posedge clk) begin
    if (mem_we) line_store[wr_addr] <= pixel;
    mem_q <= line_store[rd_addr];
  end

  // window origin of the current pixel
  logic [HW-1:0]     pix_r;
  logic [COL_AW-1:0] pix_c;
  logic [HW-1:0]     top_row;
  logic [COL_AW-1:0] left_col;

  assign top_row  = pix_r + HW'(1) - HW'(wh);
  assign left_col = COL_AW'({1'b0, pix_c} + WW'(1) - WW'(ww));

  // shared restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem, div_den;
  logic [CNT_W-1:0] div_cnt;
  logic [DEN_W:0]   div_sh;
  logic [DEN_W+1:0] div_diff;
  logic             div_done;

  assign div_sh   = {div_rem, div_quo[NUM_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, div_den};
  assign div_done = (div_cnt == '0);

  // window sum sequencer
  logic [KW-1:0]            win_i, win_j;
  logic                     issuing, pend;
  logic signed [ACC_W-1:0]  acc;
  logic                     neg;
  logic                     row_last, col_last;
  logic [2*KW-1:0]          area;

  assign rd_addr = {ROW_AW'(top_row[ROW_AW-1:0] + ROW_AW'(win_i)), left_col + COL_AW'(win_j)};
  assign area    = wh * ww;

  logic [NUM_W-1:0]        q_mean;
  logic [PIXEL_BITS-1:0]   mean_word;
  assign q_mean    = neg ? (NUM_W'(0) - div_quo) : div_quo;
  assign mean_word = q_mean[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      issuing   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the output state reloads the word itself when it is taken
      if (out_take && state != S_OUT) out_valid <= 1'b0;

      // divider step
      if (!div_done) begin
        div_cnt <= div_cnt - CNT_W'(1);
        if (!div_diff[DEN_W+1]) begin
          div_rem <= div_diff[DEN_W-1:0];
          div_quo <= {div_quo[NUM_W-2:0], 1'b1};
        end else begin
          div_rem <= div_sh[DEN_W-1:0];
          div_quo <= {div_quo[NUM_W-2:0], 1'b0};
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            pix_r <= cur_r;
            pix_c <= cur_c;
            if (gate) begin
              // row index of the window: (r + 1 - wh) / step_rows
              div_quo <= NUM_W'(cur_r + HW'(1) - HW'(wh));
              div_rem <= '0;
              div_den <= DEN_W'(sh);
              div_cnt <= CNT_W'(NUM_W);
              state   <= S_DROW;
            end
          end
        end
        S_DROW: begin
          if (div_done) begin
            if (div_rem == '0 && div_quo < NUM_W'(out_height)) begin
              row_last <= (div_quo + NUM_W'(1) == NUM_W'(out_height)) ||
                          ({1'b0, pix_r} + (HW+1)'(sh) >= {1'b0, ih});
              div_quo  <= NUM_W'(left_col);
              div_rem  <= '0;
              div_den  <= DEN_W'(sw);
              div_cnt  <= CNT_W'(NUM_W);
              state    <= S_DCOL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DCOL: begin
          if (div_done) begin
            if (div_rem == '0 && div_quo < NUM_W'(out_width)) begin
              col_last <= (div_quo + NUM_W'(1) == NUM_W'(out_width)) ||
                          ({1'b0, pix_c} + WW'(sw) >= iw);
              win_i    <= '0;
              win_j    <= '0;
              acc      <= '0;
              issuing  <= 1'b1;
              state    <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SUM: begin
          // one read per cycle, each accumulated in the next cycle
          pend <= issuing;
          if (issuing) begin
            if (win_j == ww - KW'(1)) begin
              win_j <= '0;
              if (win_i == wh - KW'(1)) issuing <= 1'b0;
              else win_i <= win_i + KW'(1);
            end else begin
              win_j <= win_j + KW'(1);
            end
          end
          if (pend) acc <= acc + ACC_W'(mem_q);
          if (!issuing && !pend) begin
            neg     <= acc[ACC_W-1];
            div_quo <= acc[ACC_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
            div_rem <= '0;
            div_den <= DEN_W'(area);
            div_cnt <= CNT_W'(NUM_W);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_take) begin
            average   <= mean_word;
            plane_end <= row_last && col_last;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider is idle whenever pixels are taken
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> div_done)
    else $error("divider busy while idle");

  // line store reads land only while a window is being summed
  a_pend_sum: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SUM))
    else $error("read pending outside summing");

  // leaving the output state always presents a word
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || !out_stall)) |=> out_valid)
    else $error("result word lost");

  // a division never starts on an accepted pixel above or left of the first window corner
  a_gate: assert property (@(posedge clk) disable iff (rst)
    (accept && !gate) |=> (state == S_IDLE))
    else $error("sequencer started without a window");

endmodule
